>>> hw/rtl/dcd_pkg.sv
// Shared types and constants for the dead channel detector.
`default_nettype none
package dcd_pkg;

    localparam int NUM_PEAKS   = 8;
    localparam int PEAK_W      = 11;
    localparam int TIME_W      = 20;
    localparam int CNT_W       = 4;
    localparam int QT_W        = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 8;
    localparam int MAX_CH_DEF  = 8;

    localparam int TIME_LSB = NUM_PEAKS * PEAK_W;
    localparam int CNT_LSB  = TIME_LSB + TIME_W;

    localparam logic [CNT_W-1:0]  RST_CHANS   = CNT_W'(8);
    localparam logic [PEAK_W-1:0] RST_DEAD_TH = PEAK_W'(-600);
    localparam logic [PEAK_W-1:0] RST_ACT_TH  = PEAK_W'(-400);
    localparam logic [QT_W-1:0]   RST_SUSTAIN = QT_W'(5000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANS   = 2'd0,
        CFG_DEAD_TH = 2'd1,
        CFG_ACT_TH  = 2'd2,
        CFG_SUSTAIN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]  chans;
        logic [PEAK_W-1:0] dead_th;
        logic [PEAK_W-1:0] act_th;
        logic [QT_W-1:0]   sustain;
    } t_cfg;

    typedef struct packed {
        logic n_dead;
        logic r_dead;
        logic r_osa;
    } t_chan_st;

endpackage
`default_nettype wire

>>> hw/rtl/dead_channel_detector_core.sv
// Dead channel detector top level: input register, channel cells, result register.
// One audio block is taken per transfer and one result transfer comes back for it, from the
// result register that follows the input register. A new block can be accepted in every cycle
// when the output is not stalled: all channel cells compare, add and update in parallel between
// the input register and the result register, and that path (a 32-bit saturating add and compare
// per channel) sets the rate. State resets at once; no clearing pass.
`default_nettype none
module dead_channel_detector_core #(
    parameter int MAX_CHANNELS = dcd_pkg::MAX_CH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // peak_ch0..peak_ch7 (11b each), block_time_us (20b), block_channel_count (4b)
    input  wire logic [dcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // dead_mask (8b)
    output logic [dcd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // block_accepted (1b)
    output logic                                 m_axis_tuser,
    input  wire logic                            i_cfg_we,
    input  wire logic [dcd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dcd_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import dcd_pkg::*;

    t_cfg                    w_cfg;
    logic                    r_in_valid;
    logic [IN_TDATA_W-1:0]   r_in_data;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_mask;
    logic                    r_out_acc;
    logic                    w_adv;
    logic                    w_acc;
    logic [NUM_PEAKS-1:0]    w_inuse;
    logic [NUM_PEAKS-1:0]    w_act;
    logic [NUM_PEAKS-1:0]    w_ndead;
    logic [NUM_PEAKS-1:0]    w_dead_vec;
    logic [NUM_PEAKS-1:0]    w_osa_vec;
    logic [TIME_W-1:0]       w_dt;
    logic [CNT_W-1:0]        w_cnt;
    t_chan_st                w_st [MAX_CHANNELS];

    dcd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
    end

    assign w_dt  = r_in_data[TIME_LSB +: TIME_W];
    assign w_cnt = r_in_data[CNT_LSB +: CNT_W];
    assign w_acc = (w_cfg.chans != '0) && (w_cfg.chans <= CNT_W'(MAX_CHANNELS))
                   && (w_cnt == w_cfg.chans);

    for (genvar k = 0; k < NUM_PEAKS; k++) begin : g_peak
        if (k < MAX_CHANNELS) begin : g_used
            logic [PEAK_W-1:0] w_peak;
            logic              w_other;
            assign w_peak     = r_in_data[k*PEAK_W +: PEAK_W];
            assign w_inuse[k] = CNT_W'(k) < w_cfg.chans;
            assign w_act[k]   = w_inuse[k] && ($signed(w_peak) > $signed(w_cfg.act_th));
            assign w_other    = |(w_act & ~(NUM_PEAKS'(1) << k));

            dcd_chan u_chan (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_upd   (w_adv && w_acc && w_inuse[k]),
                .i_peak  (w_peak),
                .i_dt    (w_dt),
                .i_other (w_other),
                .i_cfg   (w_cfg),
                .o_st    (w_st[k])
            );

            assign w_ndead[k]    = w_st[k].n_dead;
            assign w_dead_vec[k] = w_st[k].r_dead;
            assign w_osa_vec[k]  = w_st[k].r_osa;
        end else begin : g_unused
            assign w_inuse[k]    = 1'b0;
            assign w_act[k]      = 1'b0;
            assign w_ndead[k]    = 1'b0;
            assign w_dead_vec[k] = 1'b0;
            assign w_osa_vec[k]  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_mask <= OUT_TDATA_W'(w_ndead & w_inuse);
            r_out_acc  <= w_acc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_mask;
    assign m_axis_tuser  = r_out_acc;

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !w_acc |=> $stable(w_dead_vec))
        else $error("rejected block changed dead flags");

    a_dead_needs_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dead_vec & ~w_osa_vec) == '0)
        else $error("dead flag set without other-channel activity");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata & ~OUT_TDATA_W'(w_inuse)) == '0))
        else $error("dead mask has bits beyond the channel count");

endmodule
`default_nettype wire

>>> hw/rtl/dcd_cfg.sv
// Configuration register bank of the dead channel detector.
`default_nettype none
module dcd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dcd_pkg::CFG_W-1:0]     i_cfg_wdata,
    output dcd_pkg::t_cfg                      o_cfg
);
    import dcd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chans   <= RST_CHANS;
            r_cfg.dead_th <= RST_DEAD_TH;
            r_cfg.act_th  <= RST_ACT_TH;
            r_cfg.sustain <= RST_SUSTAIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHANS:   r_cfg.chans   <= i_cfg_wdata[CNT_W-1:0];
                CFG_DEAD_TH: r_cfg.dead_th <= i_cfg_wdata[PEAK_W-1:0];
                CFG_ACT_TH:  r_cfg.act_th  <= i_cfg_wdata[PEAK_W-1:0];
                CFG_SUSTAIN: r_cfg.sustain <= i_cfg_wdata[QT_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hw/rtl/dcd_chan.sv
// Per-channel quiet timer, activity bit and dead flag.
`default_nettype none
module dcd_chan (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_upd,
    input  wire logic [dcd_pkg::PEAK_W-1:0] i_peak,
    input  wire logic [dcd_pkg::TIME_W-1:0] i_dt,
    input  wire logic                       i_other,
    input  dcd_pkg::t_cfg                   i_cfg,
    output dcd_pkg::t_chan_st               o_st
);
    import dcd_pkg::*;

    logic [QT_W-1:0] r_qt, n_qt;
    logic            r_osa, n_osa;
    logic            r_dead, n_dead;
    logic            w_quiet;
    logic [QT_W:0]   w_sum;
    logic [QT_W-1:0] w_t;
    logic            w_osa_q;

    assign w_quiet = $signed(i_peak) <= $signed(i_cfg.dead_th);
    assign w_sum   = {1'b0, r_qt} + (QT_W+1)'(i_dt);
    assign w_t     = w_sum[QT_W] ? '1 : w_sum[QT_W-1:0];
    assign w_osa_q = r_osa | i_other;

    always_comb begin
        n_qt   = r_qt;
        n_osa  = r_osa;
        n_dead = r_dead;
        if (i_upd) begin
            if (w_quiet) begin
                n_qt   = w_t;
                n_osa  = w_osa_q;
                n_dead = r_dead | ((w_t >= i_cfg.sustain) && w_osa_q);
            end else begin
                n_qt   = '0;
                n_osa  = 1'b0;
                n_dead = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qt   <= '0;
            r_osa  <= 1'b0;
            r_dead <= 1'b0;
        end else begin
            r_qt   <= n_qt;
            r_osa  <= n_osa;
            r_dead <= n_dead;
        end
    end

    assign o_st.n_dead = n_dead;
    assign o_st.r_dead = r_dead;
    assign o_st.r_osa  = r_osa;

endmodule
`default_nettype wire

>>> tb/dead_channel_detector_core_test.sv
// Self-checking stream testbench for dead_channel_detector_core with a scoreboard class.
module dead_channel_detector_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dcd_pkg::*;

    localparam int MAX_CH      = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 50;
    localparam int LONG_BLOCKS = 40;
    localparam int PHASE_ITEMS = 85;

    typedef logic [NUM_PEAKS-1:0][PEAK_W-1:0] peaks_t;

    typedef struct {
        logic [OUT_TDATA_W-1:0] mask;
        logic                   accepted;
    } dead_report_t;

    class dead_channel_tracker;
        logic [CNT_W-1:0]         chans;
        logic signed [PEAK_W-1:0] dead_th;
        logic signed [PEAK_W-1:0] act_th;
        logic [QT_W-1:0]          sustain;
        logic [QT_W-1:0]          quiet_us [NUM_PEAKS];
        bit                       osa [NUM_PEAKS];
        bit                       dead [NUM_PEAKS];
        dead_report_t             pending_reports [$];
        int                       errors;

        function new();
            chans   = RST_CHANS;
            dead_th = RST_DEAD_TH;
            act_th  = RST_ACT_TH;
            sustain = RST_SUSTAIN;
            for (int c = 0; c < NUM_PEAKS; c++) begin
                quiet_us[c] = '0;
                osa[c]      = 1'b0;
                dead[c]     = 1'b0;
            end
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_CHANS:   chans   = val[CNT_W-1:0];
                CFG_DEAD_TH: dead_th = val[PEAK_W-1:0];
                CFG_ACT_TH:  act_th  = val[PEAK_W-1:0];
                CFG_SUSTAIN: sustain = val[QT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_block(logic [IN_TDATA_W-1:0] d);
            logic signed [PEAK_W-1:0] pk [NUM_PEAKS];
            bit                       hot [NUM_PEAKS];
            logic [TIME_W-1:0]        dt;
            logic [CNT_W-1:0]         cnt;
            logic [QT_W:0]            sum;
            int                       n;
            bit                       ok;
            bit                       other;
            dead_report_t             r;
            dt  = d[TIME_LSB +: TIME_W];
            cnt = d[CNT_LSB +: CNT_W];
            n   = (int'(chans) > MAX_CH) ? MAX_CH : int'(chans);
            ok  = (chans >= 1) && (int'(chans) <= MAX_CH) && (cnt == chans);
            for (int c = 0; c < NUM_PEAKS; c++) begin
                pk[c]  = d[c*PEAK_W +: PEAK_W];
                hot[c] = (c < n) && (pk[c] > act_th);
            end
            if (ok) begin
                for (int c = 0; c < n; c++) begin
                    other = 1'b0;
                    for (int o = 0; o < n; o++)
                        if (o != c && hot[o])
                            other = 1'b1;
                    if (pk[c] <= dead_th) begin
                        sum = {1'b0, quiet_us[c]} + dt;
                        quiet_us[c] = sum[QT_W] ? '1 : sum[QT_W-1:0];
                        if (other)
                            osa[c] = 1'b1;
                        if (quiet_us[c] >= sustain && osa[c])
                            dead[c] = 1'b1;
                    end else begin
                        quiet_us[c] = '0;
                        osa[c]      = 1'b0;
                        dead[c]     = 1'b0;
                    end
                end
            end
            r.mask = '0;
            for (int c = 0; c < n; c++)
                r.mask[c] = dead[c];
            r.accepted = ok;
            pending_reports.push_back(r);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] mask, logic accepted);
            dead_report_t want;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected result transfer: dead_mask %0h, accepted %b",
                             $time, mask, accepted);
                return;
            end
            want = pending_reports.pop_front();
            if (mask !== want.mask)
                report("dead_mask", 32'(want.mask), 32'(mask));
            if (accepted !== want.accepted)
                report("block_accepted", 32'(want.accepted), 32'(accepted));
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;

    dead_channel_tracker tracker = new();
    int                  cycle_count = 0;
    bit                  tx_steady = 1'b0;
    bit                  rx_steady = 1'b0;
    int                  ch_mode [NUM_PEAKS];

    dead_channel_detector_core #(
        .MAX_CHANNELS(MAX_CH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata, m_axis_tuser);
            if (i_cfg_we)
                tracker.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_block(s_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results outstanding", $time,
                     tracker.pending_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: ready runs and stalls of random length, or ready throughout in steady phases
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_steady || $urandom_range(0, 99) < 60) begin
                m_axis_tready <= 1'b1;
                repeat (rx_steady ? 1 : $urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (idle_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_block(peaks_t pk, logic [TIME_W-1:0] dt, logic [CNT_W-1:0] cnt);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cnt, dt, pk};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (tracker.pending_reports.size() != 0);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(int chans, int dth, int ath, logic [QT_W-1:0] sus);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_cfg(CFG_CHANS, CFG_W'(chans));
        write_cfg(CFG_DEAD_TH, CFG_W'(dth));
        write_cfg(CFG_ACT_TH, CFG_W'(ath));
        write_cfg(CFG_SUSTAIN, sus);
        i_cfg_we <= 1'b0;
    endtask

    // mode 0: mostly silent, 1: mostly active, 2: anything
    function automatic logic [PEAK_W-1:0] pick_peak(int mode, int dth, int ath);
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 5))
                0: return PEAK_W'(dth);
                1: return PEAK_W'(dth + 1);
                2: return PEAK_W'(ath);
                3: return PEAK_W'(ath + 1);
                4: return PEAK_W'(-1024);
                default: return PEAK_W'(1023);
            endcase
        end
        if (mode == 2 || r < 20)
            return PEAK_W'($urandom_range(0, 2047));
        if (mode == 0) begin
            lo = -1024;
            hi = dth;
        end else begin
            hi = 1023;
            lo = (ath < 1023) ? ath + 1 : 1023;
        end
        return PEAK_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic random_block(int chans, int dth, int ath);
        peaks_t            pk;
        logic [TIME_W-1:0] dt;
        logic [CNT_W-1:0]  cnt;
        int                r;
        for (int c = 0; c < NUM_PEAKS; c++) begin
            if ($urandom_range(0, 24) == 0)
                ch_mode[c] = $urandom_range(0, 2);
            pk[c] = pick_peak(ch_mode[c], dth, ath);
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            dt = '0;
        else if (r < 10)
            dt = '1;
        else if (r < 30)
            dt = TIME_W'($urandom_range(0, 4095));
        else
            dt = TIME_W'($urandom);
        if (chans < 1 || chans > MAX_CH || $urandom_range(0, 9) == 0)
            cnt = CNT_W'($urandom_range(0, 15));
        else
            cnt = CNT_W'(chans);
        send_block(pk, dt, cnt);
    endtask

    task automatic directed_part();
        peaks_t pk;
        // reset settings: eight channels, -60 dB dead, -40 dB active, 5 s sustain
        pk = {NUM_PEAKS{PEAK_W'(-1024)}};
        send_block(pk, '1, CNT_W'(8));
        pk[7] = PEAK_W'(1023);
        repeat (4) send_block(pk, '1, CNT_W'(8));
        // count mismatch keeps the state
        send_block(pk, '1, CNT_W'(7));
        send_block(pk, '1, CNT_W'(0));
        send_block(pk, '1, CNT_W'(15));
        // just above and exactly at the thresholds
        pk[2] = PEAK_W'(-600);
        pk[3] = PEAK_W'(-599);
        pk[6] = PEAK_W'(-399);
        pk[7] = PEAK_W'(-400);
        send_block(pk, '0, CNT_W'(8));
        send_block(pk, TIME_W'(1), CNT_W'(8));

        // zero sustain, everything silent, nearly everything active
        configure(3, 1023, -1024, '0);
        pk    = {NUM_PEAKS{PEAK_W'(1023)}};
        pk[0] = PEAK_W'(-1024);
        pk[1] = PEAK_W'(-1023);
        pk[2] = PEAK_W'(-1023);
        send_block(pk, '0, CNT_W'(3));
        send_block(pk, '0, CNT_W'(8));

        // no channel count can match
        configure(0, -600, -400, RST_SUSTAIN);
        send_block(pk, '1, CNT_W'(0));
        send_block(pk, '1, CNT_W'(8));
        configure(15, -600, -400, RST_SUSTAIN);
        send_block(pk, '1, CNT_W'(15));

        // single channel: never another one active
        configure(1, -1024, 1023, '1);
        pk = {NUM_PEAKS{PEAK_W'(-1024)}};
        send_block(pk, '1, CNT_W'(1));
        pk[0] = PEAK_W'(1023);
        send_block(pk, '1, CNT_W'(1));
        pk[0] = PEAK_W'(-1024);
        send_block(pk, '1, CNT_W'(1));
    endtask

    initial begin
        int               chans;
        int               dth;
        int               ath;
        int               n_items;
        logic [QT_W-1:0]  sus;
        peaks_t           pk;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0, 4:    chans = 8;
                1:       chans = 1;
                2:       chans = 2;
                5:       chans = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
                default: chans = $urandom_range(1, 8);
            endcase
            if (p == 6) begin
                dth = -1024;
                ath = 1023;
            end else if (p == 7) begin
                dth = 1023;
                ath = -1024;
            end else begin
                dth = -900 + int'($urandom_range(0, 600));
                ath = dth - 100 + int'($urandom_range(0, 400));
            end
            case ($urandom_range(0, 4))
                0:       sus = '0;
                1:       sus = QT_W'($urandom_range(0, 3_000_000));
                2:       sus = RST_SUSTAIN;
                3:       sus = QT_W'($urandom);
                default: sus = QT_W'($urandom_range(0, 1_000_000));
            endcase
            n_items = (p == 5) ? 30 : PHASE_ITEMS;
            for (int c = 0; c < NUM_PEAKS; c++)
                ch_mode[c] = $urandom_range(0, 2);
            configure(chans, dth, ath, sus);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat (n_items) random_block(chans, dth, ath);
        end

        // long silence on channel 0 with the longest blocks, channel 1 active
        configure(2, -600, -400, '1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (LONG_BLOCKS) begin
            for (int c = 0; c < NUM_PEAKS; c++)
                pk[c] = PEAK_W'($urandom_range(0, 2047));
            pk[0] = PEAK_W'(-1024 + int'($urandom_range(0, 424)));
            pk[1] = PEAK_W'(-399 + int'($urandom_range(0, 1422)));
            send_block(pk, '1, CNT_W'(2));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (20) random_block(2, -600, -400);

        s_axis_tvalid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
